@@ rtl/erd_pkg.sv @@
// Shared types and constants for the escaped record deframer.
// Used by erd_parser, erd_out_buf and escaped_record_deframer.
`timescale 1ns / 1ps

package erd_pkg;

  localparam logic [7:0]  MARKER       = 8'hFF;
  localparam logic [7:0]  ESCAPE       = 8'hFE;
  localparam logic [7:0]  ESC_OFFSET   = 8'd2;
  localparam logic [15:0] CELL_LENGTH  = 16'd53;
  localparam logic [15:0] HEADER_BYTES = 16'd12;

  localparam logic [15:0] MAX_LEN_RESET   = 16'd16384;
  localparam logic [6:0]  CELL_CODE_RESET = 7'd3;

  // register indexes on the configuration port
  localparam logic [1:0] CFG_MAX_LEN   = 2'd0;
  localparam logic [1:0] CFG_CELL_CODE = 2'd1;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [1:0] ERR_MARK_HEAD = 2'd0;
  localparam logic [1:0] ERR_MARK_BODY = 2'd1;
  localparam logic [1:0] ERR_TOO_LONG  = 2'd2;
  localparam logic [1:0] ERR_CELL_LEN  = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] micros;
    logic [31:0] seconds;
    logic [7:0]  origin;
    logic [6:0]  protocol;
    logic        direction;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
    logic        last;
    logic [1:0]  error_code;
  } result_t;

endpackage

@@ rtl/erd_parser.sv @@
// Byte parser: marker hunt, unescaping, header assembly and checks, payload count.
// Depends on erd_pkg for constants and the result struct.
`timescale 1ns / 1ps

module erd_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic [7:0]        in_byte,
  input  logic [15:0]       max_len,
  input  logic [6:0]        cell_code,
  output logic              res_valid,
  output erd_pkg::result_t  res
);

  typedef enum logic [1:0] {PH_HUNT, PH_HEAD, PH_BODY} phase_t;

  phase_t      phase_r, phase_nxt;
  logic        esc_r, esc_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [23:0] micros_r, micros_nxt;
  logic [31:0] seconds_r, seconds_nxt;
  logic [7:0]  origin_r, origin_nxt;
  logic [7:0]  flag_r, flag_nxt;
  logic [15:0] length_r, length_nxt;

  logic [7:0]  val;
  logic        take;
  logic [15:0] cnt_inc;

  always_comb begin
    val         = esc_r ? (in_byte + erd_pkg::ESC_OFFSET) : in_byte;
    cnt_inc     = cnt_r + 16'd1;
    take        = 1'b0;
    phase_nxt   = phase_r;
    esc_nxt     = esc_r;
    cnt_nxt     = cnt_r;
    micros_nxt  = micros_r;
    seconds_nxt = seconds_r;
    origin_nxt  = origin_r;
    flag_nxt    = flag_r;
    length_nxt  = length_r;
    res_valid   = 1'b0;
    res         = '0;

    case (phase_r)
      PH_HEAD, PH_BODY: begin
        if (in_fire) begin
          if (esc_r) begin
            esc_nxt = 1'b0;
            take    = 1'b1;
          end else if (in_byte == erd_pkg::MARKER) begin
            // marker inside a record: flag it and restart the header
            res_valid      = 1'b1;
            res.kind       = erd_pkg::KIND_ERROR;
            res.last       = 1'b1;
            res.error_code = (phase_r == PH_HEAD) ? erd_pkg::ERR_MARK_HEAD
                                                  : erd_pkg::ERR_MARK_BODY;
            phase_nxt      = PH_HEAD;
            cnt_nxt        = '0;
          end else if (in_byte == erd_pkg::ESCAPE) begin
            esc_nxt = 1'b1;
          end else begin
            take = 1'b1;
          end
        end
      end
      default: begin
        if (in_fire && in_byte == erd_pkg::MARKER) begin
          phase_nxt = PH_HEAD;
          cnt_nxt   = '0;
          esc_nxt   = 1'b0;
        end
      end
    endcase

    if (take && phase_r == PH_HEAD) begin
      if (cnt_r <= 16'd2) begin
        micros_nxt = {micros_r[15:0], val};
      end else if (cnt_r >= 16'd4 && cnt_r <= 16'd7) begin
        seconds_nxt = {seconds_r[23:0], val};
      end else if (cnt_r == 16'd8) begin
        origin_nxt = val;
      end else if (cnt_r == 16'd9) begin
        flag_nxt = val;
      end else if (cnt_r >= 16'd10) begin
        length_nxt = {length_r[7:0], val};
      end
      cnt_nxt = cnt_inc;
      if (cnt_inc >= erd_pkg::HEADER_BYTES) begin
        res_valid = 1'b1;
        if (flag_nxt[7:1] == cell_code && length_nxt != erd_pkg::CELL_LENGTH) begin
          res.kind       = erd_pkg::KIND_ERROR;
          res.last       = 1'b1;
          res.error_code = erd_pkg::ERR_CELL_LEN;
          phase_nxt      = PH_HUNT;
        end else if (length_nxt > max_len) begin
          res.kind       = erd_pkg::KIND_ERROR;
          res.last       = 1'b1;
          res.error_code = erd_pkg::ERR_TOO_LONG;
          phase_nxt      = PH_HUNT;
        end else begin
          res.kind           = erd_pkg::KIND_HEADER;
          res.micros         = micros_nxt;
          res.seconds        = seconds_nxt;
          res.origin         = origin_nxt;
          res.protocol       = flag_nxt[7:1];
          res.direction      = flag_nxt[0];
          res.payload_length = length_nxt;
          res.last           = (length_nxt == 16'd0);
          cnt_nxt            = '0;
          phase_nxt          = (length_nxt == 16'd0) ? PH_HUNT : PH_BODY;
        end
      end
    end

    if (take && phase_r == PH_BODY) begin
      cnt_nxt       = cnt_inc;
      res_valid     = 1'b1;
      res.kind      = erd_pkg::KIND_PAYLOAD;
      res.data_byte = val;
      if (cnt_inc >= length_r) begin
        res.last  = 1'b1;
        phase_nxt = PH_HUNT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      esc_r   <= 1'b0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      esc_r   <= esc_nxt;
      cnt_r   <= cnt_nxt;
    end
    micros_r  <= micros_nxt;
    seconds_r <= seconds_nxt;
    origin_r  <= origin_nxt;
    flag_r    <= flag_nxt;
    length_r  <= length_nxt;
  end

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.kind == erd_pkg::KIND_ERROR) |-> res.last)
    else $error("error result without last");

  a_esc_in_record: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> (phase_r == PH_HEAD || phase_r == PH_BODY))
    else $error("escape pending outside a record");

  a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HEAD) |-> (cnt_r < erd_pkg::HEADER_BYTES))
    else $error("header byte count overran");

endmodule

@@ rtl/erd_out_buf.sv @@
// Two-entry result buffer (head plus skid register) between parser and output port.
// Depends on erd_pkg for the result struct.
`timescale 1ns / 1ps

module erd_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  erd_pkg::result_t  push_data,
  output logic              not_full,
  output logic              out_valid,
  input  logic              out_ready,
  output erd_pkg::result_t  out_data
);

  logic             head_v_r, head_v_nxt;
  logic             skid_v_r, skid_v_nxt;
  erd_pkg::result_t head_r, head_nxt;
  erd_pkg::result_t skid_r, skid_nxt;
  logic             pop;

  assign pop       = head_v_r && out_ready;
  assign not_full  = !skid_v_r;
  assign out_valid = head_v_r;
  assign out_data  = head_r;

  always_comb begin
    head_v_nxt = head_v_r;
    skid_v_nxt = skid_v_r;
    head_nxt   = head_r;
    skid_nxt   = skid_r;
    if (pop) begin
      if (skid_v_r) begin
        head_nxt = skid_r;
        if (push) begin
          skid_nxt = push_data;
        end else begin
          skid_v_nxt = 1'b0;
        end
      end else if (push) begin
        head_nxt = push_data;
      end else begin
        head_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!head_v_r) begin
        head_nxt   = push_data;
        head_v_nxt = 1'b1;
      end else begin
        skid_nxt   = push_data;
        skid_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      head_v_r <= head_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> head_v_r)
    else $error("skid entry held without head entry");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("output result changed while stalled");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> not_full)
    else $error("push into a full buffer");

endmodule

@@ rtl/escaped_record_deframer.sv @@
// Each result is registered in the output buffer's head or skid register before out_valid offers it.
// Throughput: one byte per cycle; in_ready drops only while two results wait at the output.
// Results always leave from a register; the two-entry output buffer sets the slack.
// Reset (rst_n low, synchronous): hunt for a marker, empty output buffer,
// max_record_length back to 16384 and cell_protocol_code back to 3.
`timescale 1ns / 1ps

module escaped_record_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [23:0] out_micros,
  output logic [31:0] out_seconds,
  output logic [7:0]  out_origin,
  output logic [6:0]  out_protocol,
  output logic        out_direction,
  output logic [15:0] out_payload_length,
  output logic [7:0]  out_data_byte,
  output logic        out_last,
  output logic [1:0]  out_error_code,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0]      max_len_r;
  logic [6:0]       cell_code_r;
  logic             in_fire;
  logic             res_valid;
  erd_pkg::result_t res;
  erd_pkg::result_t out_res;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r   <= erd_pkg::MAX_LEN_RESET;
      cell_code_r <= erd_pkg::CELL_CODE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        erd_pkg::CFG_MAX_LEN:   max_len_r   <= cfg_data;
        erd_pkg::CFG_CELL_CODE: cell_code_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  erd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_byte   (in_byte),
    .max_len   (max_len_r),
    .cell_code (cell_code_r),
    .res_valid (res_valid),
    .res       (res)
  );

  erd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .not_full  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign out_kind           = out_res.kind;
  assign out_micros         = out_res.micros;
  assign out_seconds        = out_res.seconds;
  assign out_origin         = out_res.origin;
  assign out_protocol       = out_res.protocol;
  assign out_direction      = out_res.direction;
  assign out_payload_length = out_res.payload_length;
  assign out_data_byte      = out_res.data_byte;
  assign out_last           = out_res.last;
  assign out_error_code     = out_res.error_code;

endmodule
